// File: rtl/core/fpl_pkg.sv
package fpl_pkg;

    localparam int DISPLAY_WIDTH  = 128;
    localparam int DISPLAY_HEIGHT = 64;
    localparam int STORE_BYTES    = 1024;
    localparam int ROW_LIMIT      = (DISPLAY_HEIGHT / 8) * 8;
    localparam int ADDR_W         = $clog2(STORE_BYTES);
    localparam int IDX_W          = 14;
    localparam int COORD_W        = 8;
    localparam int EPS_W          = 11;

    localparam logic [1:0] MODE_PLOT  = 2'd0;
    localparam logic [1:0] MODE_READ  = 2'd1;
    localparam logic [1:0] MODE_LINE  = 2'd2;
    localparam logic [1:0] MODE_CLEAR = 2'd3;

    localparam logic [1:0] COLOR_CLEAR = 2'd0;
    localparam logic [1:0] COLOR_SET   = 2'd1;
    localparam logic [1:0] COLOR_RESET = 2'd1;

    typedef struct packed {
        logic load;
        logic step;
    } fpl_walk_ctl_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               last;
    } fpl_pix_t;

endpackage

// File: rtl/core/fpl_line_walk.sv
module fpl_line_walk (
    input  logic                           clk,
    input  fpl_pkg::fpl_walk_ctl_t         ctl,
    input  logic [fpl_pkg::COORD_W-1:0]    x1,
    input  logic [fpl_pkg::COORD_W-1:0]    y1,
    input  logic [fpl_pkg::COORD_W-1:0]    x2,
    input  logic [fpl_pkg::COORD_W-1:0]    y2,
    output fpl_pkg::fpl_pix_t              pix
);
    import fpl_pkg::*;

    logic [COORD_W-1:0]      x_reg, y_reg, end_reg, dmaj_reg, dmin_reg;
    logic                    major_x_reg, major_up_reg, minor_up_reg, straight_reg;
    logic signed [EPS_W-1:0] eps_reg;

    logic               vert, horiz;
    logic [COORD_W-1:0] dx, dy, ymin, ymax, xmin, xmax;
    logic               sl_major_x;

    logic [COORD_W-1:0]      major_pos, major_nx, minor_pos, minor_nx;
    logic signed [EPS_W-1:0] e1;
    logic signed [EPS_W:0]   twice;
    logic                    minor_go;

    always_comb
    begin
        vert       = (x1 == x2);
        horiz      = (y1 == y2);
        dx         = (x2 > x1) ? x2 - x1 : x1 - x2;
        dy         = (y2 > y1) ? y2 - y1 : y1 - y2;
        ymin       = (y1 < y2) ? y1 : y2;
        ymax       = (y1 < y2) ? y2 : y1;
        xmin       = (x1 < x2) ? x1 : x2;
        xmax       = (x1 < x2) ? x2 : x1;
        sl_major_x = (dx > dy);
    end

    // shared step unit: error add and compare, major and minor steps per pixel
    always_comb
    begin
        major_pos = major_x_reg ? x_reg : y_reg;
        minor_pos = major_x_reg ? y_reg : x_reg;
        major_nx  = major_up_reg ? major_pos + 1'b1 : major_pos - 1'b1;
        minor_nx  = minor_up_reg ? minor_pos + 1'b1 : minor_pos - 1'b1;
        e1        = eps_reg + $signed({{(EPS_W-COORD_W){1'b0}}, dmin_reg});
        twice     = {e1, 1'b0};
        minor_go  = !straight_reg && (twice >= $signed({{(EPS_W+1-COORD_W){1'b0}}, dmaj_reg}));
        pix.x     = x_reg;
        pix.y     = y_reg;
        pix.last  = straight_reg ? (major_pos == end_reg) : (major_nx == end_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            eps_reg      <= '0;
            straight_reg <= vert || horiz;
            if (vert)
            begin
                x_reg        <= x1;
                y_reg        <= ymin;
                end_reg      <= ymax;
                major_x_reg  <= 1'b0;
                major_up_reg <= 1'b1;
                minor_up_reg <= 1'b1;
                dmaj_reg     <= '0;
                dmin_reg     <= '0;
            end
            else if (horiz)
            begin
                x_reg        <= xmin;
                y_reg        <= y1;
                end_reg      <= xmax;
                major_x_reg  <= 1'b1;
                major_up_reg <= 1'b1;
                minor_up_reg <= 1'b1;
                dmaj_reg     <= '0;
                dmin_reg     <= '0;
            end
            else
            begin
                x_reg        <= x1;
                y_reg        <= y1;
                major_x_reg  <= sl_major_x;
                end_reg      <= sl_major_x ? x2 : y2;
                major_up_reg <= sl_major_x ? (x2 > x1) : (y2 > y1);
                minor_up_reg <= sl_major_x ? (y2 > y1) : (x2 > x1);
                dmaj_reg     <= sl_major_x ? dx : dy;
                dmin_reg     <= sl_major_x ? dy : dx;
            end
        end
        else if (ctl.step)
        begin
            if (major_x_reg)
            begin
                x_reg <= major_nx;
                if (minor_go)
                    y_reg <= minor_nx;
            end
            else
            begin
                y_reg <= major_nx;
                if (minor_go)
                    x_reg <= minor_nx;
            end
            eps_reg <= minor_go ? e1 - $signed({{(EPS_W-COORD_W){1'b0}}, dmaj_reg}) : e1;
        end
    end

endmodule

// File: rtl/core/framebuffer_pixel_line_engine.sv
// Page-organized monochrome framebuffer (1024 bytes) with plot, read, line and
// clear commands. After reset, and for every clear command, the store is swept
// to zero one byte per cycle, with in_stall high. Each pixel is a
// read-modify-write through the single store port: plot passes through the
// read and write states, read through the read and response states plus any
// wait on out_stall, and a line through the read and write states for each
// drawn pixel. The Bresenham walker steps once per pixel. Read results sit in
// an output register, so new commands are taken while a result waits.
module framebuffer_pixel_line_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [1:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    mode,
    input  logic [fpl_pkg::COORD_W-1:0]   x_a,
    input  logic [fpl_pkg::COORD_W-1:0]   y_a,
    input  logic [fpl_pkg::COORD_W-1:0]   x_b,
    input  logic [fpl_pkg::COORD_W-1:0]   y_b,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          pixel_value,
    output logic                          in_range
);
    import fpl_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_WR,
        ST_RESP
    } state_t;

    state_t            state_reg;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic              op_read_reg;
    logic [1:0]        draw_color_reg;
    logic              out_valid_reg, pixel_value_reg, in_range_reg;

    logic [7:0]        store [STORE_BYTES];
    logic [7:0]        rd_data_reg;

    fpl_walk_ctl_t     walk_ctl;
    fpl_pix_t          pix;
    logic [COORD_W-1:0] wx2, wy2;

    logic              accept, pix_in_rng, pix_in_store;
    logic [IDX_W-1:0]  idx;
    logic [7:0]        bit_mask, wr_byte;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic              pix_bit;

    assign accept    = in_valid && (state_reg == ST_IDLE);
    assign in_stall  = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign walk_ctl.load = accept && (mode != MODE_CLEAR);
    assign walk_ctl.step = (state_reg == ST_WR);
    assign wx2 = (mode == MODE_LINE) ? x_b : x_a;
    assign wy2 = (mode == MODE_LINE) ? y_b : y_a;

    fpl_line_walk u_walk (
        .clk (clk),
        .ctl (walk_ctl),
        .x1  (x_a),
        .y1  (y_a),
        .x2  (wx2),
        .y2  (wy2),
        .pix (pix)
    );

    always_comb
    begin
        pix_in_rng   = ({1'b0, pix.x} < 9'(DISPLAY_WIDTH)) && ({1'b0, pix.y} < 9'(ROW_LIMIT));
        idx          = IDX_W'(pix.x) + IDX_W'(DISPLAY_WIDTH) * IDX_W'(pix.y[7:3]);
        pix_in_store = (idx < IDX_W'(STORE_BYTES));
        bit_mask     = 8'd1 << pix.y[2:0];
        pix_bit      = rd_data_reg[pix.y[2:0]];
        unique case (draw_color_reg)
            COLOR_SET:   wr_byte = rd_data_reg | bit_mask;
            COLOR_CLEAR: wr_byte = rd_data_reg & ~bit_mask;
            default:     wr_byte = rd_data_reg ^ bit_mask;
        endcase
        if (state_reg == ST_CLEAR)
        begin
            mem_addr = clr_cnt_reg;
            mem_we   = 1'b1;
        end
        else
        begin
            mem_addr = idx[ADDR_W-1:0];
            mem_we   = (state_reg == ST_WR) && pix_in_rng && pix_in_store;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            store[mem_addr] <= (state_reg == ST_CLEAR) ? 8'h00 : wr_byte;
        rd_data_reg <= store[mem_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            clr_cnt_reg     <= '0;
            op_read_reg     <= 1'b0;
            draw_color_reg  <= COLOR_RESET;
            out_valid_reg   <= 1'b0;
            pixel_value_reg <= 1'b0;
            in_range_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                draw_color_reg <= cfg_data;
            if (out_valid_reg && !out_stall && (state_reg != ST_RESP))
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == ADDR_W'(STORE_BYTES - 1))
                        state_reg <= ST_IDLE;
                end
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        op_read_reg <= (mode == MODE_READ);
                        clr_cnt_reg <= '0;
                        state_reg   <= (mode == MODE_CLEAR) ? ST_CLEAR : ST_RD;
                    end
                end
                ST_RD:
                    state_reg <= op_read_reg ? ST_RESP : ST_WR;
                ST_WR:
                begin
                    if (pix.last)
                        state_reg <= ST_IDLE;
                    else
                        state_reg <= ST_RD;
                end
                ST_RESP:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg   <= 1'b1;
                        in_range_reg    <= pix_in_rng;
                        pixel_value_reg <= pix_in_rng && pix_in_store && pix_bit;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_value = pixel_value_reg;
    assign in_range    = in_range_reg;

endmodule

// File: rtl/core/fpl_checker.sv
module fpl_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_stall,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic                        pixel_value,
    input logic                        in_range
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(pixel_value) && $stable(in_range))
        else $error("stalled result word changed");

    a_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !in_range |-> !pixel_value)
        else $error("out-of-range read returned a set pixel");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("no busy cycle after an accepted word");

    a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !$past(out_valid) |-> $past(in_stall))
        else $error("result word raised while idle");

endmodule

bind framebuffer_pixel_line_engine fpl_checker u_fpl_checker (.*);

// File: verif/tb_framebuffer_pixel_line_engine.sv
module tb_framebuffer_pixel_line_engine;
    timeunit 1ns;
    timeprecision 1ps;

    import fpl_pkg::*;

    localparam logic [1:0] COLOR_INVERT     = 2'd2;
    localparam logic [1:0] COLOR_INVERT_ALT = 2'd3;
    localparam int         CYCLE_LIMIT      = 4000000;

    typedef logic [COORD_W-1:0] coord_t;

    typedef struct packed {
        logic pixel_value;
        logic in_range;
    } pixel_read_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [1:0] mode;
    coord_t     x_a;
    coord_t     y_a;
    coord_t     x_b;
    coord_t     y_b;
    logic       out_valid;
    logic       out_stall;
    logic       pixel_value;
    logic       in_range;

    logic [7:0]  pixel_mirror [STORE_BYTES];
    logic [1:0]  mirror_color;
    pixel_read_t pending_reads [$];

    int     mismatch_count;
    int     cycle_count;
    int     hold_left;
    bit     quiet;
    coord_t last_x;
    coord_t last_y;

    framebuffer_pixel_line_engine uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .x_a         (x_a),
        .y_a         (y_a),
        .x_b         (x_b),
        .y_b         (y_b),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_value (pixel_value),
        .in_range    (in_range)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random stall, forced hold-off, or none
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left = hold_left - 1;
        end
        else if (quiet)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < 15);
    end

    // ---------------- frame mirror ----------------

    function automatic bit mirror_locate(input int x, input int y, output int idx);
        idx = 0;
        if (x < 0 || x >= DISPLAY_WIDTH || y < 0 || y >= ROW_LIMIT)
            return 1'b0;
        idx = x + DISPLAY_WIDTH * (y / 8);
        return 1'b1;
    endfunction

    function automatic void mirror_put_pixel(input int x, input int y);
        int         idx;
        logic [7:0] mask;
        if (!mirror_locate(x, y, idx) || idx >= STORE_BYTES)
            return;
        mask = 8'd1 << (y % 8);
        case (mirror_color)
            COLOR_CLEAR: pixel_mirror[idx] = pixel_mirror[idx] & ~mask;
            COLOR_SET:   pixel_mirror[idx] = pixel_mirror[idx] | mask;
            default:     pixel_mirror[idx] = pixel_mirror[idx] ^ mask;
        endcase
    endfunction

    function automatic void mirror_draw_line(input int x1, input int y1,
                                             input int x2, input int y2);
        int lo, hi, i, sx, sy, dx, dy, x, y, err;
        if (x1 == x2)
        begin
            lo = (y1 < y2) ? y1 : y2;
            hi = (y1 < y2) ? y2 : y1;
            for (i = lo; i <= hi; i++)
                mirror_put_pixel(x1, i);
        end
        else if (y1 == y2)
        begin
            lo = (x1 < x2) ? x1 : x2;
            hi = (x1 < x2) ? x2 : x1;
            for (i = lo; i <= hi; i++)
                mirror_put_pixel(i, y1);
        end
        else
        begin
            sx = (x2 > x1) ? 1 : -1;
            sy = (y2 > y1) ? 1 : -1;
            dx = (x2 > x1) ? x2 - x1 : x1 - x2;
            dy = (y2 > y1) ? y2 - y1 : y1 - y2;
            x = x1;
            y = y1;
            err = 0;
            if (dx > dy)
            begin
                for (; x != x2; x += sx)
                begin
                    mirror_put_pixel(x, y);
                    err += dy;
                    if (2 * err >= dx)
                    begin
                        y += sy;
                        err -= dx;
                    end
                end
            end
            else
            begin
                for (; y != y2; y += sy)
                begin
                    mirror_put_pixel(x, y);
                    err += dx;
                    if (2 * err >= dy)
                    begin
                        x += sx;
                        err -= dy;
                    end
                end
            end
        end
    endfunction

    function automatic void mirror_apply(input logic [1:0] m, input coord_t xa,
                                         input coord_t ya, input coord_t xb,
                                         input coord_t yb);
        int          idx;
        pixel_read_t r;
        case (m)
            MODE_PLOT:
                mirror_put_pixel(xa, ya);
            MODE_READ:
            begin
                r = '0;
                if (mirror_locate(xa, ya, idx))
                begin
                    r.in_range = 1'b1;
                    if (idx < STORE_BYTES)
                        r.pixel_value = pixel_mirror[idx][ya % 8];
                end
                pending_reads.push_back(r);
            end
            MODE_LINE:
                mirror_draw_line(xa, ya, xb, yb);
            default:
                for (int i = 0; i < STORE_BYTES; i++)
                    pixel_mirror[i] = 8'h00;
        endcase
    endfunction

    // ---------------- checking ----------------

    task automatic report_mismatch(input string what, input int got, input int want);
        begin
            mismatch_count++;
            $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
        end
    endtask

    always @(posedge clk)
    begin
        pixel_read_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reads.size() == 0)
                report_mismatch("unexpected read word", 1, 0);
            else
            begin
                want = pending_reads.pop_front();
                if (pixel_value !== want.pixel_value)
                    report_mismatch("pixel_value", pixel_value, want.pixel_value);
                if (in_range !== want.in_range)
                    report_mismatch("in_range", in_range, want.in_range);
            end
        end
    end

    // ---------------- driving ----------------

    task automatic send_word(input logic [1:0] m, input coord_t xa, input coord_t ya,
                             input coord_t xb, input coord_t yb);
        int gap;
        begin
            gap = (!quiet && $urandom_range(99) < 15) ? $urandom_range(4, 1) : 0;
            @(negedge clk);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            mode     <= m;
            x_a      <= xa;
            y_a      <= ya;
            x_b      <= xb;
            y_b      <= yb;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            mirror_apply(m, xa, ya, xb, yb);
        end
    endtask

    task automatic drop_valid();
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    // a trailing read proves every earlier command has retired
    task automatic wait_idle();
        begin
            send_word(MODE_READ, '0, '0, '0, '0);
            drop_valid();
            while (pending_reads.size() != 0)
                @(posedge clk);
            repeat (16) @(posedge clk);
        end
    endtask

    task automatic write_color(input logic [1:0] c);
        begin
            wait_idle();
            @(negedge clk);
            cfg_valid <= 1'b1;
            cfg_data  <= c;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            mirror_color = c;
            @(negedge clk);
            cfg_valid <= 1'b0;
        end
    endtask

    function automatic coord_t pick_x();
        return ($urandom_range(99) < 80) ? coord_t'($urandom_range(DISPLAY_WIDTH - 1))
                                         : coord_t'($urandom_range(255));
    endfunction

    function automatic coord_t pick_y();
        return ($urandom_range(99) < 80) ? coord_t'($urandom_range(ROW_LIMIT - 1))
                                         : coord_t'($urandom_range(255));
    endfunction

    task automatic send_random_item(input int read_pct);
        int         r;
        logic [1:0] m;
        coord_t     xa, ya, xb, yb;
        begin
            r  = $urandom_range(99);
            xa = pick_x();
            ya = pick_y();
            xb = pick_x();
            yb = pick_y();
            if (r < read_pct)
            begin
                m = MODE_READ;
                if ($urandom_range(1))
                begin
                    xa = last_x;
                    ya = last_y;
                end
            end
            else if (r < 98)
            begin
                m = ($urandom_range(99) < 55) ? MODE_PLOT : MODE_LINE;
                if (m == MODE_LINE && $urandom_range(1))
                begin
                    xb = xa + coord_t'($urandom_range(16)) - 8'd8;
                    yb = ya + coord_t'($urandom_range(16)) - 8'd8;
                end
                if (m == MODE_LINE && $urandom_range(3) == 0)
                    yb = ya;
                else if (m == MODE_LINE && $urandom_range(3) == 0)
                    xb = xa;
                last_x = xa;
                last_y = ya;
            end
            else
                m = MODE_CLEAR;
            send_word(m, xa, ya, xb, yb);
        end
    endtask

    // ---------------- tests ----------------

    task automatic test_pixel_extremes();
        begin
            send_word(MODE_PLOT, 8'd0, 8'd0, 8'd255, 8'd255);
            send_word(MODE_PLOT, 8'd127, 8'd63, 8'd0, 8'd0);
            send_word(MODE_PLOT, 8'd255, 8'd255, 8'd0, 8'd0);
            send_word(MODE_READ, 8'd0, 8'd0, 8'd0, 8'd0);
            send_word(MODE_READ, 8'd127, 8'd63, 8'd0, 8'd0);
            send_word(MODE_READ, 8'd127, 8'd0, 8'd0, 8'd0);
            send_word(MODE_READ, 8'd128, 8'd0, 8'd0, 8'd0);
            send_word(MODE_READ, 8'd0, 8'd64, 8'd0, 8'd0);
            send_word(MODE_READ, 8'd255, 8'd255, 8'd0, 8'd0);
            drop_valid();
        end
    endtask

    task automatic test_color_modes();
        begin
            write_color(COLOR_CLEAR);
            send_word(MODE_PLOT, 8'd127, 8'd63, 8'd0, 8'd0);
            send_word(MODE_READ, 8'd127, 8'd63, 8'd0, 8'd0);
            write_color(COLOR_INVERT);
            send_word(MODE_PLOT, 8'd5, 8'd13, 8'd0, 8'd0);
            send_word(MODE_READ, 8'd5, 8'd13, 8'd0, 8'd0);
            write_color(COLOR_INVERT_ALT);
            send_word(MODE_PLOT, 8'd5, 8'd13, 8'd0, 8'd0);
            send_word(MODE_READ, 8'd5, 8'd13, 8'd0, 8'd0);
            write_color(COLOR_SET);
        end
    endtask

    task automatic test_line_shapes();
        begin
            send_word(MODE_LINE, 8'd10, 8'd63, 8'd10, 8'd3);
            send_word(MODE_LINE, 8'd127, 8'd40, 8'd0, 8'd40);
            send_word(MODE_LINE, 8'd20, 8'd20, 8'd20, 8'd20);
            send_word(MODE_LINE, 8'd0, 8'd0, 8'd9, 8'd3);
            send_word(MODE_READ, 8'd9, 8'd3, 8'd0, 8'd0);
            send_word(MODE_LINE, 8'd50, 8'd63, 8'd47, 8'd10);
            send_word(MODE_READ, 8'd47, 8'd10, 8'd0, 8'd0);
            send_word(MODE_LINE, 8'd120, 8'd50, 8'd255, 8'd200);
            send_word(MODE_READ, 8'd121, 8'd51, 8'd0, 8'd0);
            send_word(MODE_CLEAR, 8'd0, 8'd0, 8'd0, 8'd0);
            send_word(MODE_READ, 8'd0, 8'd40, 8'd0, 8'd0);
            drop_valid();
        end
    endtask

    task automatic test_random_traffic();
        logic [1:0] colors [6];
        begin
            colors = '{COLOR_SET, COLOR_INVERT, COLOR_CLEAR, COLOR_INVERT_ALT,
                       COLOR_INVERT, COLOR_SET};
            foreach (colors[i])
            begin
                write_color(colors[i]);
                repeat (170) send_random_item(38);
            end
            drop_valid();
        end
    endtask

    task automatic test_no_idle();
        begin
            wait_idle();
            quiet = 1'b1;
            repeat (180) send_random_item(40);
            drop_valid();
            quiet = 1'b0;
        end
    endtask

    task automatic test_output_hold();
        begin
            wait_idle();
            hold_left = 400;
            repeat (60) send_random_item(70);
            drop_valid();
        end
    endtask

    task automatic test_drain_pause();
        begin
            repeat (6)
            begin
                repeat (20) send_random_item(45);
                drop_valid();
                while (pending_reads.size() != 0)
                    @(posedge clk);
            end
        end
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        cfg_valid      = 1'b0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        mode           = MODE_PLOT;
        x_a            = '0;
        y_a            = '0;
        x_b            = '0;
        y_b            = '0;
        out_stall      = 1'b0;
        mismatch_count = 0;
        cycle_count    = 0;
        hold_left      = 0;
        quiet          = 1'b0;
        last_x         = '0;
        last_y         = '0;
        mirror_color   = COLOR_RESET;
        for (int i = 0; i < STORE_BYTES; i++)
            pixel_mirror[i] = 8'h00;

        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_pixel_extremes();
        test_color_modes();
        test_line_shapes();
        test_random_traffic();
        test_no_idle();
        test_output_hold();
        test_drain_pause();

        wait_idle();
        repeat (50) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/fpl_pkg.sv
rtl/core/fpl_line_walk.sv
rtl/core/framebuffer_pixel_line_engine.sv
rtl/core/fpl_checker.sv
verif/tb_framebuffer_pixel_line_engine.sv
